// ----- sv/ppt_pkg.sv -----
`timescale 1ns / 1ps
package ppt_pkg;

  localparam int AddrW = 128;
  localparam int LenW  = 8;
  localparam int PrioW = 16;
  localparam int CntW  = 8;

  localparam logic [1:0] OpAdd    = 2'd0;
  localparam logic [1:0] OpDel    = 2'd1;
  localparam logic [1:0] OpLookup = 2'd2;
  localparam logic [1:0] OpNop    = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StBadLen   = 2'd3;

  localparam logic [LenW-1:0] MaxLenV4 = 8'd32;
  localparam logic [LenW-1:0] MaxLenV6 = 8'd128;

  typedef enum logic [1:0] {
    CmpAfter  = 2'd0,
    CmpBefore = 2'd1,
    CmpExact  = 2'd2,
    CmpInner  = 2'd3
  } cmp_e;

  // address is left aligned: IPv4 sits in the top 32 bits
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
    logic [PrioW-1:0] prio;
  } entry_t;

  function automatic cmp_e prt_cmp(logic [AddrW-1:0] ka, logic [LenW-1:0] klen,
                                   logic [AddrW-1:0] ea, logic [LenW-1:0] elen);
    logic [LenW-1:0]  len;
    logic [AddrW-1:0] m;
    logic [AddrW-1:0] a;
    logic [AddrW-1:0] b;
    cmp_e             r;
    len = (klen < elen) ? klen : elen;
    m   = (len == '0) ? '0 : ({AddrW{1'b1}} << (MaxLenV6 - len));
    a   = ka & m;
    b   = ea & m;
    if (a < b) r = CmpBefore;
    else if (a > b) r = CmpAfter;
    else if (klen == elen) r = CmpExact;
    else if (klen > elen) r = CmpInner;
    else r = CmpAfter;
    return r;
  endfunction

endpackage

// ----- sv/ppt_cell.sv -----
`timescale 1ns / 1ps
module ppt_cell
  import ppt_pkg::*;
(
  input  logic   clk_i,
  input  logic   shift_i,
  input  entry_t d_i,
  output entry_t q_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

// ----- sv/prefix_priority_table.sv -----
`timescale 1ns / 1ps
// Sorted prefix table held in a ring of ENTRIES cells, slot 0 at the head.
// Add, delete and lookup each rotate the ring once past the one compare unit
// at the head of the ring, then give their result; the next request is taken
// once that result has moved to the output register. Requests with a bad
// prefix length or op 3 skip the scan and give their result directly.
// A new request is taken while the previous result waits on the output.
module prefix_priority_table
  import ppt_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // address_high, address_low, prefix_len, priority_req
  input  logic [151:0] s_axis_tdata,
  // op, is_ipv6
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, matched, priority_out, zero pad
  output logic [23:0]  m_axis_tdata
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;
  localparam logic [1:0] SDone = 2'd2;

  localparam logic [1:0] MNone = 2'd0;
  localparam logic [1:0] MIns  = 2'd1;
  localparam logic [1:0] MDel  = 2'd2;

  localparam logic [CntW-1:0] Depth = CntW'(ENTRIES);
  localparam logic [CntW-1:0] Last  = CntW'(ENTRIES - 1);

  logic [1:0] state_q, state_d, mode_q, mode_d;
  logic [CntW-1:0] cnt_q, cnt_d, v4_q, v4_d, p_q, p_d;
  logic [CntW-1:0] start_q, stop_q;
  logic found_q, found_d;
  logic [1:0] op_q;
  logic v6_q;
  logic [AddrW-1:0] key_q;
  logic [LenW-1:0] klen_q;
  logic [PrioW-1:0] prio_q;
  entry_t hold_q, hold_d;
  logic [1:0] st_q, st_d;
  logic mt_q, mt_d;
  logic [PrioW-1:0] po_q, po_d;
  logic ov_q;
  logic [23:0] od_q;

  entry_t cq [ENTRIES];
  entry_t feed, head;
  logic scan;
  cmp_e cmp;
  logic in_range, exact;

  logic [1:0] in_op;
  logic in_v6;
  logic [LenW-1:0] in_len, in_max;
  logic in_bad;

  assign scan = (state_q == SScan);
  assign head = cq[0];

  genvar k;
  generate
    for (k = 0; k < ENTRIES; k++) begin : g_cell
      entry_t d;
      if (k == ENTRIES - 1) begin : g_tail
        assign d = feed;
      end else begin : g_mid
        assign d = cq[k+1];
      end
      ppt_cell u_cell (.clk_i(clk_i), .shift_i(scan), .d_i(d), .q_o(cq[k]));
    end
  endgenerate

  assign in_op  = s_axis_tuser[1:0];
  assign in_v6  = s_axis_tuser[2];
  assign in_max = in_v6 ? MaxLenV6 : MaxLenV4;
  assign in_len = (in_op == OpLookup) ? in_max : s_axis_tdata[135:128];
  assign in_bad = (in_len == '0) || (in_len > in_max);

  assign s_axis_tready = (state_q == SIdle);

  assign cmp      = prt_cmp(key_q, klen_q, head.addr, head.len);
  assign in_range = (p_q >= start_q) && (p_q < stop_q);
  assign exact    = in_range && (cmp == CmpExact);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    v4_d    = v4_q;
    p_d     = p_q;
    found_d = found_q;
    hold_d  = hold_q;
    st_d    = st_q;
    mt_d    = mt_q;
    po_d    = po_q;
    feed    = head;
    case (state_q)
      SIdle: begin
        if (s_axis_tvalid) begin
          st_d    = StOk;
          mt_d    = 1'b0;
          po_d    = '0;
          mode_d  = MNone;
          found_d = 1'b0;
          p_d     = '0;
          if (in_op == OpNop) begin
            state_d = SDone;
          end else if (in_bad) begin
            st_d    = StBadLen;
            state_d = SDone;
          end else begin
            state_d = SScan;
          end
        end
      end
      SScan: begin
        if (mode_q == MIns) begin
          feed   = hold_q;
          hold_d = head;
        end else if (mode_q == MDel) begin
          feed = cq[1];
        end else if (!found_q &&
                     ((in_range && cmp != CmpAfter) || p_q == stop_q)) begin
          found_d = 1'b1;
          case (op_q)
            OpAdd: begin
              if (exact) begin
                feed = '{addr: head.addr, len: head.len, prio: prio_q};
              end else if (cnt_q >= Depth) begin
                st_d = StFull;
              end else begin
                feed   = '{addr: key_q, len: klen_q, prio: prio_q};
                hold_d = head;
                mode_d = MIns;
              end
            end
            OpDel: begin
              if (exact) begin
                feed   = cq[1];
                mode_d = MDel;
              end else begin
                st_d = StNotFound;
              end
            end
            default: begin
              if (in_range && (cmp == CmpExact || cmp == CmpInner)) begin
                mt_d = 1'b1;
                po_d = head.prio;
              end else begin
                st_d = StNotFound;
              end
            end
          endcase
        end
        p_d = p_q + 1'b1;
        if (p_q == Last) begin
          state_d = SDone;
          if (!found_d) begin
            st_d = (op_q == OpAdd) ? StFull : StNotFound;
          end
          if (mode_d == MIns) begin
            cnt_d = cnt_q + 1'b1;
            v4_d  = v6_q ? v4_q : v4_q + 1'b1;
          end else if (mode_d == MDel) begin
            cnt_d = cnt_q - 1'b1;
            v4_d  = v6_q ? v4_q : v4_q - 1'b1;
          end
        end
      end
      SDone: begin
        if (!ov_q || m_axis_tready) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      mode_q  <= MNone;
      cnt_q   <= '0;
      v4_q    <= '0;
      p_q     <= '0;
      found_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      v4_q    <= v4_d;
      p_q     <= p_d;
      found_q <= found_d;
      if (state_q == SDone && (!ov_q || m_axis_tready)) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    st_q   <= st_d;
    mt_q   <= mt_d;
    po_q   <= po_d;
    if (s_axis_tvalid && s_axis_tready) begin
      op_q    <= in_op;
      v6_q    <= in_v6;
      klen_q  <= in_len;
      prio_q  <= s_axis_tdata[151:136];
      key_q   <= in_v6 ? {s_axis_tdata[63:0], s_axis_tdata[127:64]}
                       : {s_axis_tdata[95:64], 96'd0};
      start_q <= in_v6 ? v4_q : '0;
      stop_q  <= in_v6 ? cnt_q : v4_q;
    end
    if (state_q == SDone && (!ov_q || m_axis_tready)) begin
      od_q <= {5'd0, po_q, mt_q, st_q};
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan |-> !s_axis_tready) else $error("ready during scan");
  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q <= cnt_q) && (cnt_q <= Depth)) else $error("entry counts out of order");
  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan |-> (p_q <= Last)) else $error("scan ran past the ring");
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |=> $stable(cnt_q)) else $error("count moved while idle");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb
  import ppt_pkg::*;
;

  localparam int Depth = 64;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [151:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;

  prefix_priority_table #(.ENTRIES(Depth)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #4 clk_i = ~clk_i;

  typedef struct packed {
    logic [1:0]  op;
    logic        v6;
    logic [63:0] ah;
    logic [63:0] al;
    logic [7:0]  plen;
    logic [15:0] prio;
  } req_t;

  typedef struct packed {
    logic [1:0]  st;
    logic        hit;
    logic [15:0] prio;
  } rsp_t;

  // shadow table
  logic [63:0] t_ah [Depth];
  logic [63:0] t_al [Depth];
  logic [7:0]  t_len [Depth];
  logic [15:0] t_prio [Depth];
  int          n_all, n_v4;

  rsp_t rsp_q[$];
  req_t req_q[$];
  int   errors, n_rsp, n_hits, n_full;
  bit   hold_off, no_idle;

  function automatic logic [63:0] mask_hi(int len);
    if (len == 0) return '0;
    if (len >= 64) return '1;
    return ~64'd0 << (64 - len);
  endfunction

  function automatic logic [63:0] mask_lo(int len);
    if (len <= 64) return '0;
    if (len >= 128) return '1;
    return ~64'd0 << (128 - len);
  endfunction

  function automatic cmp_e order_vs(bit v6, logic [63:0] kh, logic [63:0] kl, int klen, int idx);
    int          len;
    logic [63:0] a, b, c, d, m;
    len = klen < t_len[idx] ? klen : t_len[idx];
    if (v6) begin
      a = kh & mask_hi(len); b = t_ah[idx] & mask_hi(len);
      c = kl & mask_lo(len); d = t_al[idx] & mask_lo(len);
    end else begin
      m = len == 0 ? '0 : ((64'hffffffff << (32 - len)) & 64'hffffffff);
      a = 0; b = 0; c = kl & m; d = t_al[idx] & m;
    end
    if (a < b || (a == b && c < d)) return CmpBefore;
    if (a > b || c > d) return CmpAfter;
    if (klen == t_len[idx]) return CmpExact;
    if (klen > t_len[idx]) return CmpInner;
    return CmpAfter;
  endfunction

  function automatic rsp_t table_apply(req_t r);
    rsp_t        o;
    logic [63:0] kh, kl;
    int          plen, maxlen, lo, hi, i;
    cmp_e        c;
    o = '0;
    kh = r.v6 ? r.ah : 64'd0;
    kl = r.v6 ? r.al : {32'd0, r.al[31:0]};
    maxlen = r.v6 ? 128 : 32;
    plen = (r.op == OpLookup) ? maxlen : r.plen;
    lo = r.v6 ? n_v4 : 0;
    hi = r.v6 ? n_all : n_v4;
    c = CmpAfter;
    if (r.op == OpNop) return o;
    if (plen == 0 || plen > maxlen) begin
      o.st = StBadLen;
      return o;
    end
    for (i = lo; i < hi; i++) begin
      c = order_vs(r.v6, kh, kl, plen, i);
      if (c != CmpAfter) break;
    end
    if (r.op == OpAdd) begin
      if (i < hi && c == CmpExact) t_prio[i] = r.prio;
      else if (n_all >= Depth) o.st = StFull;
      else begin
        for (int j = n_all; j > i; j--) begin
          t_ah[j] = t_ah[j-1]; t_al[j] = t_al[j-1];
          t_len[j] = t_len[j-1]; t_prio[j] = t_prio[j-1];
        end
        t_ah[i] = kh; t_al[i] = kl; t_len[i] = 8'(plen); t_prio[i] = r.prio;
        n_all++;
        if (!r.v6) n_v4++;
      end
    end else if (r.op == OpDel) begin
      if (i < hi && c == CmpExact) begin
        for (int j = i; j + 1 < n_all; j++) begin
          t_ah[j] = t_ah[j+1]; t_al[j] = t_al[j+1];
          t_len[j] = t_len[j+1]; t_prio[j] = t_prio[j+1];
        end
        n_all--;
        if (i < n_v4) n_v4--;
      end else o.st = StNotFound;
    end else begin
      if (i < hi && (c == CmpExact || c == CmpInner)) begin
        o.hit = 1'b1; o.prio = t_prio[i];
      end else o.st = StNotFound;
    end
    return o;
  endfunction

  task automatic send_req(req_t r);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r.prio, r.plen, r.al, r.ah};
    s_axis_tuser <= {r.v6, r.op};
    req_q.push_back(r);
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic stop_req();
    s_axis_tvalid <= 1'b0;
  endtask

  // acceptance-time prediction keeps order with the table
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_t r;
      rsp_t e;
      r = req_q.pop_front();
      e = table_apply(r);
      rsp_q.push_back(e);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      rsp_t got, e;
      got = {m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata[18:3]};
      n_rsp++;
      if (rsp_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = rsp_q.pop_front();
        if (got.st == StFull) n_full++;
        if (got.hit) n_hits++;
        if (got !== e) begin
          $display("%0t: mismatch exp st=%0d hit=%0d prio=%h got st=%0d hit=%0d prio=%h",
                   $time, e.st, e.hit, e.prio, got.st, got.hit, got.prio);
          errors++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off) m_axis_tready <= 1'b0;
      else if (!no_idle && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else m_axis_tready <= 1'b1;
    end
  end

  function automatic req_t mk(logic [1:0] op, bit v6, logic [63:0] ah, logic [63:0] al,
                              logic [7:0] plen, logic [15:0] prio);
    req_t r;
    r = '{op, v6, ah, al, plen, prio};
    return r;
  endfunction

  // pick addresses from a small pool so prefixes overlap often
  function automatic req_t rnd_req(bit lookup_heavy);
    req_t r;
    int   k;
    k = $urandom_range(0, 99);
    r.op = (k < (lookup_heavy ? 30 : 50)) ? OpAdd : (k < 70 ? OpDel : (k < 98 ? OpLookup : OpNop));
    r.v6 = 1'($urandom_range(0, 1));
    r.ah = {2'($urandom_range(0, 3)), 30'd0, 32'($urandom)};
    if ($urandom_range(0, 3) == 0) r.ah = r.ah ^ {$urandom, $urandom};
    r.al = {$urandom, $urandom};
    if ($urandom_range(0, 1)) begin
      r.al[31:0] = {3'($urandom_range(0, 7)), 29'd0} | ($urandom & 32'hff);
    end
    r.plen = r.v6 ? 8'($urandom_range(1, 128)) : 8'($urandom_range(1, 32));
    if ($urandom_range(0, 30) == 0) r.plen = 8'($urandom);
    r.prio = 16'($urandom);
    return r;
  endfunction

  typedef struct {
    req_t r;
    bit   chk;
    rsp_t e;
  } row_t;

  row_t rows[$];

  initial begin
    errors = 0; n_rsp = 0; n_hits = 0; n_full = 0; n_all = 0; n_v4 = 0;
    hold_off = 0; no_idle = 0;
    rows = '{
      '{mk(OpLookup, 0, 0, 64'h0a000001, 0, 0), 1, '{StNotFound, 0, 0}},
      '{mk(OpDel, 1, '1, '1, 128, 0), 1, '{StNotFound, 0, 0}},
      '{mk(OpAdd, 0, 0, 0, 0, 5), 1, '{StBadLen, 0, 0}},
      '{mk(OpAdd, 0, 0, 0, 33, 5), 1, '{StBadLen, 0, 0}},
      '{mk(OpAdd, 1, 0, 0, 129, 5), 1, '{StBadLen, 0, 0}},
      '{mk(OpAdd, 1, 0, 0, 255, 5), 1, '{StBadLen, 0, 0}},
      '{mk(OpNop, 1, '1, '1, 255, 16'hffff), 1, '{StOk, 0, 0}},
      '{mk(OpAdd, 0, '1, 64'hffffffff_0a000000, 8, 16'h0001), 1, '{StOk, 0, 0}},
      '{mk(OpAdd, 0, 0, 64'h0a010000, 16, 16'hffff), 1, '{StOk, 0, 0}},
      '{mk(OpAdd, 0, 0, 64'h0, 1, 16'h0000), 1, '{StOk, 0, 0}},
      '{mk(OpAdd, 0, 0, 64'hffffffff, 32, 16'h1234), 1, '{StOk, 0, 0}},
      '{mk(OpLookup, 0, 0, 64'h0a010203, 0, 0), 0, '{0, 0, 0}},
      '{mk(OpLookup, 0, 0, 64'h0a020203, 0, 0), 0, '{0, 0, 0}},
      '{mk(OpAdd, 1, '1, '1, 128, 16'hbeef), 1, '{StOk, 0, 0}},
      '{mk(OpAdd, 1, 64'h2001_0db8_0000_0000, 0, 32, 16'h0042), 1, '{StOk, 0, 0}},
      '{mk(OpAdd, 1, 0, 0, 1, 16'h0007), 1, '{StOk, 0, 0}},
      '{mk(OpAdd, 1, 64'h2001_0db8_0000_0000, 0, 32, 16'h0043), 1, '{StOk, 0, 0}},
      '{mk(OpLookup, 1, 64'h2001_0db8_1234_0000, 5, 0, 0), 0, '{0, 0, 0}},
      '{mk(OpLookup, 1, '1, '1, 0, 0), 0, '{0, 0, 0}},
      '{mk(OpLookup, 1, 64'h8000_0000_0000_0000, 0, 0, 0), 0, '{0, 0, 0}},
      '{mk(OpDel, 0, 0, 64'h0a010000, 16, 0), 1, '{StOk, 0, 0}},
      '{mk(OpDel, 0, 0, 64'h0a010000, 16, 0), 1, '{StNotFound, 0, 0}},
      '{mk(OpDel, 1, 0, 0, 1, 0), 1, '{StOk, 0, 0}},
      '{mk(OpLookup, 0, 0, 64'h0a010203, 0, 0), 0, '{0, 0, 0}}
    };
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      send_req(rows[i].r);
      if (rows[i].chk && rsp_q[$] !== rows[i].e) begin
        $display("%0t: directed row %0d exp %h predicted %h", $time, i, rows[i].e, rsp_q[$]);
        errors++;
      end
    end

    // fill to capacity, then probe full and update-when-full
    while (n_all < Depth) send_req(mk(OpAdd, 1'($urandom_range(0, 1)), {$urandom, $urandom},
                                      {$urandom, $urandom}, 8'($urandom_range(1, 32)),
                                      16'($urandom)));
    send_req(mk(OpAdd, 1, 64'h1111, 64'h2222, 100, 9));
    send_req(mk(OpAdd, 1, '1, '1, 128, 16'h5555));
    send_req(mk(OpLookup, 1, '1, '1, 0, 0));

    // receiver holds off while sender keeps going
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk_i);
        hold_off = 0;
      end
      for (int i = 0; i < 10; i++) send_req(rnd_req(1));
    join
    stop_req();

    // wait until all outstanding results have drained
    wait (rsp_q.size() == 0);
    repeat (3) @(negedge clk_i);

    for (int i = 0; i < 1300; i++) begin
      if (i == 1150) no_idle = 1;
      send_req(rnd_req(i % 400 > 200));
    end
    stop_req();

    wait (rsp_q.size() == 0);
    repeat (2 * Depth + 10) @(posedge clk_i);
    $display("Ran %0d results: %0d lookup hits, %0d table-full returns", n_rsp, n_hits, n_full);
    $display("Covered bad lengths, op 3, full table, long output stall and idle gaps");
    if (errors == 0 && rsp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
